@@ sv/rlbd_pkg.sv @@
// Shared types, button codes, register indexes and reset values for the ladder debouncer.
package rlbd_pkg;

   typedef logic [2:0] btn_type;

   localparam btn_type BTN_NONE     = 3'd0;
   localparam btn_type BTN_RIGHT    = 3'd1;
   localparam btn_type BTN_LEFT     = 3'd2;
   localparam btn_type BTN_CONFIRM  = 3'd3;
   localparam btn_type BTN_BACK     = 3'd4;
   localparam btn_type BTN_VOL_UP   = 3'd5;
   localparam btn_type BTN_VOL_DOWN = 3'd6;
   localparam btn_type BTN_POWER    = 3'd7;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_TOLERANCE      = 3'd0;
   localparam csr_index_type REG_DEBOUNCE_MS    = 3'd1;
   localparam csr_index_type REG_RIGHT_LEVEL    = 3'd2;
   localparam csr_index_type REG_LEFT_LEVEL     = 3'd3;
   localparam csr_index_type REG_CONFIRM_LEVEL  = 3'd4;
   localparam csr_index_type REG_BACK_LEVEL     = 3'd5;
   localparam csr_index_type REG_VOL_UP_LEVEL   = 3'd6;
   localparam csr_index_type REG_VOL_DOWN_LEVEL = 3'd7;

   localparam logic [11:0] VD_A2_LIMIT = 12'd200;
   localparam logic [11:0] VD_A1_IDLE  = 12'd3800;

   localparam logic [11:0] RST_TOLERANCE      = 12'd120;
   localparam logic [15:0] RST_DEBOUNCE_MS    = 16'd40;
   localparam logic [11:0] RST_RIGHT_LEVEL    = 12'd3;
   localparam logic [11:0] RST_LEFT_LEVEL     = 12'd1470;
   localparam logic [11:0] RST_CONFIRM_LEVEL  = 12'd2655;
   localparam logic [11:0] RST_BACK_LEVEL     = 12'd3470;
   localparam logic [11:0] RST_VOL_UP_LEVEL   = 12'd2205;
   localparam logic [11:0] RST_VOL_DOWN_LEVEL = 12'd3;

   typedef struct packed {
      logic [11:0] tolerance;
      logic [15:0] debounce_ms;
      logic [11:0] right_level;
      logic [11:0] left_level;
      logic [11:0] confirm_level;
      logic [11:0] back_level;
      logic [11:0] vol_up_level;
      logic [11:0] vol_down_level;
   } cfg_type;

   // One classified poll as it waits between front and back.
   typedef struct packed {
      btn_type     btn;
      logic        pwr;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   function automatic logic near_level(logic [11:0] v, logic [11:0] level,
                                       logic [11:0] tol);
      logic [11:0] gap;
      gap = (v >= level) ? (v - level) : (level - v);
      return gap <= tol;
   endfunction

endpackage

@@ sv/rlbd_req_if.sv @@
// Poll channel: valid/ready handshake plus the ladder samples, power pin and timestamp.
interface rlbd_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] ladder_one;
   logic [11:0] ladder_two;
   logic        power_pin_low;
   logic [31:0] now_ms;

   modport source (output valid, ladder_one, ladder_two, power_pin_low, now_ms,
                   input ready);
   modport sink (input valid, ladder_one, ladder_two, power_pin_low, now_ms,
                 output ready);
endinterface

@@ sv/rlbd_rsp_if.sv @@
// Result channel: valid/ready handshake plus the pressed code and power-hold time.
interface rlbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  pressed;
   logic [31:0] power_held_ms;

   modport source (output valid, pressed, power_held_ms, input ready);
   modport sink (input valid, pressed, power_held_ms, output ready);
endinterface

@@ sv/resistor_ladder_button_debouncer.sv @@
// Top level of the resistor-ladder keypad debouncer: registers, front, queue and back.
//
// Each poll carries two 12-bit ladder samples, the active-low power pin and a
// millisecond timestamp, and produces exactly one result: the button code emitted
// by this poll (0 when nothing new counts) and the power-hold time in ms. The block
// takes one poll every clock cycle while req_chan.ready is high; each result
// passes through the decode queue and then the output register before it is
// presented. The sustained rate is set by the back end, which updates the
// debounce state for one poll per cycle while rsp_chan is not stalled. The
// decode queue holds QUEUE_DEPTH polls, so while the result side stalls the
// block absorbs QUEUE_DEPTH polls plus the held result before req_chan.ready
// drops. Registers are written through the csr_ port at any index 0 to 7 and
// should only change while no transaction is in flight.
module resistor_ladder_button_debouncer #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   rlbd_req_if.sink                        req_chan,
   rlbd_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [rlbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rlbd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rlbd_pkg::cfg_type  cfg_ff, cfg_in;
   rlbd_pkg::push_type push;
   rlbd_pkg::item_type head;
   logic               q_full;
   logic               q_not_empty;
   logic               pop;

   // Register file: mask each write to its register's width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rlbd_pkg::REG_TOLERANCE:      cfg_in.tolerance      = csr_wdata[11:0];
            rlbd_pkg::REG_DEBOUNCE_MS:    cfg_in.debounce_ms    = csr_wdata;
            rlbd_pkg::REG_RIGHT_LEVEL:    cfg_in.right_level    = csr_wdata[11:0];
            rlbd_pkg::REG_LEFT_LEVEL:     cfg_in.left_level     = csr_wdata[11:0];
            rlbd_pkg::REG_CONFIRM_LEVEL:  cfg_in.confirm_level  = csr_wdata[11:0];
            rlbd_pkg::REG_BACK_LEVEL:     cfg_in.back_level     = csr_wdata[11:0];
            rlbd_pkg::REG_VOL_UP_LEVEL:   cfg_in.vol_up_level   = csr_wdata[11:0];
            rlbd_pkg::REG_VOL_DOWN_LEVEL: cfg_in.vol_down_level = csr_wdata[11:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance      <= rlbd_pkg::RST_TOLERANCE;
         cfg_ff.debounce_ms    <= rlbd_pkg::RST_DEBOUNCE_MS;
         cfg_ff.right_level    <= rlbd_pkg::RST_RIGHT_LEVEL;
         cfg_ff.left_level     <= rlbd_pkg::RST_LEFT_LEVEL;
         cfg_ff.confirm_level  <= rlbd_pkg::RST_CONFIRM_LEVEL;
         cfg_ff.back_level     <= rlbd_pkg::RST_BACK_LEVEL;
         cfg_ff.vol_up_level   <= rlbd_pkg::RST_VOL_UP_LEVEL;
         cfg_ff.vol_down_level <= rlbd_pkg::RST_VOL_DOWN_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Decode each poll into a button code and push it into the queue.
   rlbd_front u_front (
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .push     (push)
   );

   // Hold decoded polls until the back end can take them.
   rlbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   // Advance debounce state and present one result per popped poll.
   rlbd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .head        (head),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

   // The power code is internal and never leaves the block.
   a_no_power_code : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.pressed != rlbd_pkg::BTN_POWER))
      else $error("power code reached the result channel");

   // An emitted button implies the power pin was released on that poll.
   a_press_excludes_power : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.pressed != rlbd_pkg::BTN_NONE)
      |-> (rsp_chan.power_held_ms == '0))
      else $error("button emitted while power hold reported");

   // The back end pops only when the queue has something in it.
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      pop |-> q_not_empty)
      else $error("pop from empty queue");

   // A pop always yields a valid result in the next cycle.
   a_pop_gives_result : assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_chan.valid)
      else $error("popped poll produced no result");

endmodule

@@ sv/rlbd_front.sv @@
// Front end: take polls and decode the ladder samples into one button code.
module rlbd_front (
   rlbd_req_if.sink            req_chan,
   input  rlbd_pkg::cfg_type   cfg,
   input  logic                q_full,
   output rlbd_pkg::push_type  push
);

   logic [11:0]       a1;
   logic [11:0]       a2;
   rlbd_pkg::btn_type btn;

   assign a1 = req_chan.ladder_one;
   assign a2 = req_chan.ladder_two;

   always_comb begin
      if (req_chan.power_pin_low) begin
         btn = rlbd_pkg::BTN_POWER;
      end else if (rlbd_pkg::near_level(a1, cfg.right_level, cfg.tolerance)) begin
         btn = rlbd_pkg::BTN_RIGHT;
      end else if (rlbd_pkg::near_level(a1, cfg.left_level, cfg.tolerance)) begin
         btn = rlbd_pkg::BTN_LEFT;
      end else if (rlbd_pkg::near_level(a1, cfg.confirm_level, cfg.tolerance)) begin
         btn = rlbd_pkg::BTN_CONFIRM;
      end else if (rlbd_pkg::near_level(a1, cfg.back_level, cfg.tolerance)) begin
         btn = rlbd_pkg::BTN_BACK;
      end else if (rlbd_pkg::near_level(a2, cfg.vol_up_level, cfg.tolerance)) begin
         btn = rlbd_pkg::BTN_VOL_UP;
      end else if (rlbd_pkg::near_level(a2, cfg.vol_down_level, cfg.tolerance)
                   && (a2 < rlbd_pkg::VD_A2_LIMIT) && (a1 > rlbd_pkg::VD_A1_IDLE)) begin
         btn = rlbd_pkg::BTN_VOL_DOWN;
      end else begin
         btn = rlbd_pkg::BTN_NONE;
      end
   end

   assign req_chan.ready   = !q_full;
   assign push.valid       = req_chan.valid && !q_full;
   assign push.item.btn    = btn;
   assign push.item.pwr    = req_chan.power_pin_low;
   assign push.item.now_ms = req_chan.now_ms;

endmodule

@@ sv/rlbd_queue.sv @@
// Short FIFO that decouples the decoder from the debounce back end.
module rlbd_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  rlbd_pkg::push_type  push,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output rlbd_pkg::item_type  head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rlbd_pkg::item_type mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.item;
      end
   end

endmodule

@@ sv/rlbd_back.sv @@
// Back end: debounce state, once-per-press emission, power-hold timing and output register.
module rlbd_back (
   input  logic                clock,
   input  logic                reset,
   input  rlbd_pkg::cfg_type   cfg,
   input  logic                q_not_empty,
   input  rlbd_pkg::item_type  head,
   output logic                pop,
   rlbd_rsp_if.source          rsp_chan
);

   rlbd_pkg::btn_type stable_ff, stable_in;
   rlbd_pkg::btn_type emitted_ff, emitted_in;
   logic [31:0]       change_ff, change_in;
   logic [31:0]       since_ff, since_in;
   logic              out_valid_ff, out_valid_in;
   rlbd_pkg::btn_type pressed_ff, pressed_in;
   logic [31:0]       held_ff, held_in;

   logic [31:0]       elapsed;
   logic              settled;
   logic [31:0]       since_next;

   assign pop        = q_not_empty && (!out_valid_ff || rsp_chan.ready);
   assign elapsed    = head.now_ms - change_ff;
   assign settled    = elapsed >= {16'd0, cfg.debounce_ms};
   assign since_next = (since_ff != '0) ? since_ff :
                       ((head.now_ms == '0) ? 32'd1 : head.now_ms);

   always_comb begin
      stable_in    = stable_ff;
      emitted_in   = emitted_ff;
      change_in    = change_ff;
      since_in     = since_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      pressed_in   = pressed_ff;
      held_in      = held_ff;
      if (pop) begin
         out_valid_in = 1'b1;
         pressed_in   = rlbd_pkg::BTN_NONE;
         held_in      = '0;
         if (head.btn != stable_ff) begin
            stable_in = head.btn;
            change_in = head.now_ms;
         end else if (settled && head.btn != rlbd_pkg::BTN_POWER) begin
            if (head.btn != rlbd_pkg::BTN_NONE && head.btn != emitted_ff) begin
               emitted_in = head.btn;
               pressed_in = head.btn;
            end else if (head.btn == rlbd_pkg::BTN_NONE) begin
               emitted_in = rlbd_pkg::BTN_NONE;
            end
         end
         if (head.pwr) begin
            since_in = since_next;
            held_in  = head.now_ms - since_next;
         end else begin
            since_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff    <= rlbd_pkg::BTN_NONE;
         emitted_ff   <= rlbd_pkg::BTN_NONE;
         change_ff    <= '0;
         since_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         stable_ff    <= stable_in;
         emitted_ff   <= emitted_in;
         change_ff    <= change_in;
         since_ff     <= since_in;
         out_valid_ff <= out_valid_in;
      end
      pressed_ff <= pressed_in;
      held_ff    <= held_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pressed       = pressed_ff;
   assign rsp_chan.power_held_ms = held_ff;

endmodule
